// ===== hw/rtl/avt_pkg.sv =====
// Shared types, constants and saturation helpers for the affine vector transform.
`timescale 1ns / 1ps

package avt_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned NUM_WORDS     = 12;
  localparam int unsigned NUM_LANES     = 3;
  localparam int unsigned TRANS_BASE    = 9;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    CMD_LOAD      = 3'd0,
    CMD_XFORM     = 3'd1,
    CMD_INV_XFORM = 3'd2,
    CMD_ROT       = 3'd3,
    CMD_INV_ROT   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic        [2:0]        cmd;
    logic        [3:0]        elem_index;
    logic signed [WORD_W-1:0] elem_value;
    logic signed [WORD_W-1:0] vec_x;
    logic signed [WORD_W-1:0] vec_y;
    logic signed [WORD_W-1:0] vec_z;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] res_x;
    logic signed [WORD_W-1:0] res_y;
    logic signed [WORD_W-1:0] res_z;
    logic                     saturated;
  } out_word_t;

  // per-word control carried down each lane
  typedef struct packed {
    logic add_trans;
    logic clip;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     clip;
  } sat_t;

  // clamp a 33-bit sum to 32 bits
  function automatic sat_t sat33(input logic signed [WORD_W:0] s);
    sat_t r;
    r.clip = s[WORD_W] ^ s[WORD_W-1];
    if (r.clip) begin
      r.word = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r.word = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_t sat_add(input logic signed [WORD_W-1:0] a,
                                   input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    return sat33(s);
  endfunction

  function automatic sat_t sat_sub(input logic signed [WORD_W-1:0] a,
                                   input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    return sat33(s);
  endfunction

endpackage

// ===== hw/rtl/avt_lane.sv =====
// One output-component lane: three fixed-point products and a saturating sum chain.
`timescale 1ns / 1ps

module avt_lane #(
  parameter int unsigned FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [avt_pkg::WORD_W-1:0]   vec_i  [3],
  input  logic signed [avt_pkg::WORD_W-1:0]   coef_i [3],
  input  logic signed [avt_pkg::WORD_W-1:0]   trans_i,
  input  avt_pkg::lane_ctl_t                  ctl_i,
  output logic signed [avt_pkg::WORD_W-1:0]   res_o,
  output logic                                clip_o
);

  localparam int unsigned PW = 2 * avt_pkg::WORD_W;

  // stage B: products
  logic signed [PW-1:0]                 prod_q [3];
  logic signed [avt_pkg::WORD_W-1:0]    trans_b_q;
  avt_pkg::lane_ctl_t                   ctl_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= PW'(vec_i[j]) * PW'(coef_i[j]);
      end
      trans_b_q <= trans_i;
      ctl_b_q   <= ctl_i;
    end
  end

  // stage C: floor shift, clamp, first sum
  logic signed [PW-1:0]              shf [3];
  logic signed [avt_pkg::WORD_W-1:0] pq  [3];
  logic [2:0]                        pclip;
  avt_pkg::sat_t                     s01;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shf[j]   = prod_q[j] >>> FRAC_BITS;
      pclip[j] = !((&shf[j][PW-1:avt_pkg::WORD_W-1]) || !(|shf[j][PW-1:avt_pkg::WORD_W-1]));
      if (pclip[j]) begin
        pq[j] = shf[j][PW-1] ? {1'b1, {(avt_pkg::WORD_W-1){1'b0}}}
                             : {1'b0, {(avt_pkg::WORD_W-1){1'b1}}};
      end else begin
        pq[j] = shf[j][avt_pkg::WORD_W-1:0];
      end
    end
    s01 = avt_pkg::sat_add(pq[0], pq[1]);
  end

  logic signed [avt_pkg::WORD_W-1:0] sum_c_q;
  logic signed [avt_pkg::WORD_W-1:0] p2_c_q;
  logic signed [avt_pkg::WORD_W-1:0] trans_c_q;
  avt_pkg::lane_ctl_t                ctl_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_c_q        <= s01.word;
      p2_c_q         <= pq[2];
      trans_c_q      <= trans_b_q;
      ctl_c_q.add_trans <= ctl_b_q.add_trans;
      ctl_c_q.clip   <= ctl_b_q.clip | (|pclip) | s01.clip;
    end
  end

  // stage D: third term
  avt_pkg::sat_t s012;
  assign s012 = avt_pkg::sat_add(sum_c_q, p2_c_q);

  logic signed [avt_pkg::WORD_W-1:0] sum_d_q;
  logic signed [avt_pkg::WORD_W-1:0] trans_d_q;
  avt_pkg::lane_ctl_t                ctl_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_d_q           <= s012.word;
      trans_d_q         <= trans_c_q;
      ctl_d_q.add_trans <= ctl_c_q.add_trans;
      ctl_d_q.clip      <= ctl_c_q.clip | s012.clip;
    end
  end

  // stage E: translation
  avt_pkg::sat_t st;
  assign st = avt_pkg::sat_add(sum_d_q, trans_d_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctl_d_q.add_trans) begin
        res_o  <= st.word;
        clip_o <= ctl_d_q.clip | st.clip;
      end else begin
        res_o  <= sum_d_q;
        clip_o <= ctl_d_q.clip;
      end
    end
  end

endmodule

// ===== hw/rtl/affine_vector_transform_unit.sv =====
// Top level of the 3x4 affine vector transform: matrix store, lanes and merge stage.
`timescale 1ns / 1ps

// Takes one word per cycle when not stalled, vector or matrix load alike. Each
// accepted vector word gives one result. The accepting edge loads the
// decode/select register. Then come multiply, two sum stages, translation and
// the output register. Three lanes, one per result component, each with three
// multipliers, run in parallel. A matrix load gives no result; one with an index
// below NUM_WORDS applies to every vector word accepted after it. When the output
// register is stalled the whole pipeline holds, and in_stall_o follows out_stall_i
// in that case. The matrix resets to identity.
module affine_vector_transform_unit #(
  parameter int unsigned FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  avt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output avt_pkg::out_word_t out_word_o
);

  localparam int unsigned W = avt_pkg::WORD_W;
  localparam logic [W-1:0] ONE_FX = W'(1) << FRAC_BITS;

  logic en;
  logic in_acc;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;

  // matrix store
  logic signed [W-1:0] mat_q [avt_pkg::NUM_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < avt_pkg::NUM_WORDS; i++) begin
        mat_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE_FX : '0;
      end
    end else if (in_acc && in_word_i.cmd == avt_pkg::CMD_LOAD &&
                 in_word_i.elem_index < 4'(avt_pkg::NUM_WORDS)) begin
      mat_q[in_word_i.elem_index] <= in_word_i.elem_value;
    end
  end

  // decode and operand select
  logic                is_vec, fwd, add_t, pre_sub;
  logic signed [W-1:0] vin  [3];
  logic signed [W-1:0] vsel [3];
  logic [2:0]          sub_clip;
  avt_pkg::sat_t       dsub [3];
  logic signed [W-1:0] coef_sel [avt_pkg::NUM_LANES][3];

  always_comb begin
    is_vec  = 1'b0;
    fwd     = 1'b0;
    add_t   = 1'b0;
    pre_sub = 1'b0;
    case (in_word_i.cmd)
      avt_pkg::CMD_XFORM: begin
        is_vec = 1'b1;
        fwd    = 1'b1;
        add_t  = 1'b1;
      end
      avt_pkg::CMD_INV_XFORM: begin
        is_vec  = 1'b1;
        pre_sub = 1'b1;
      end
      avt_pkg::CMD_ROT: begin
        is_vec = 1'b1;
        fwd    = 1'b1;
      end
      avt_pkg::CMD_INV_ROT: begin
        is_vec = 1'b1;
      end
      default: begin
        is_vec = 1'b0;
      end
    endcase
    vin[0] = in_word_i.vec_x;
    vin[1] = in_word_i.vec_y;
    vin[2] = in_word_i.vec_z;
    for (int j = 0; j < 3; j++) begin
      dsub[j] = avt_pkg::sat_sub(vin[j], mat_q[avt_pkg::TRANS_BASE + j]);
      vsel[j] = pre_sub ? dsub[j].word : vin[j];
      sub_clip[j] = pre_sub & dsub[j].clip;
    end
    for (int k = 0; k < avt_pkg::NUM_LANES; k++) begin
      for (int j = 0; j < 3; j++) begin
        coef_sel[k][j] = fwd ? mat_q[j * 3 + k] : mat_q[k * 3 + j];
      end
    end
  end

  // stage A
  logic                valid_a_q, valid_b_q, valid_c_q, valid_d_q, valid_e_q;
  logic signed [W-1:0] vec_a_q   [3];
  logic signed [W-1:0] coef_a_q  [avt_pkg::NUM_LANES][3];
  logic signed [W-1:0] trans_a_q [avt_pkg::NUM_LANES];
  avt_pkg::lane_ctl_t  ctl_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        vec_a_q[j] <= vsel[j];
      end
      for (int k = 0; k < avt_pkg::NUM_LANES; k++) begin
        coef_a_q[k]  <= coef_sel[k];
        trans_a_q[k] <= mat_q[avt_pkg::TRANS_BASE + k];
      end
      ctl_a_q.add_trans <= add_t;
      ctl_a_q.clip      <= |sub_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q   <= 1'b0;
      valid_b_q   <= 1'b0;
      valid_c_q   <= 1'b0;
      valid_d_q   <= 1'b0;
      valid_e_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_a_q   <= in_acc && is_vec;
      valid_b_q   <= valid_a_q;
      valid_c_q   <= valid_b_q;
      valid_d_q   <= valid_c_q;
      valid_e_q   <= valid_d_q;
      out_valid_q <= valid_e_q;
    end
  end

  // lanes
  logic signed [W-1:0]          lane_res  [avt_pkg::NUM_LANES];
  logic [avt_pkg::NUM_LANES-1:0] lane_clip;

  for (genvar k = 0; k < avt_pkg::NUM_LANES; k++) begin : g_lane
    avt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .vec_i  (vec_a_q),
      .coef_i (coef_a_q[k]),
      .trans_i(trans_a_q[k]),
      .ctl_i  (ctl_a_q),
      .res_o  (lane_res[k]),
      .clip_o (lane_clip[k])
    );
  end

  // merge
  avt_pkg::out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.res_x     <= lane_res[0];
      out_q.res_y     <= lane_res[1];
      out_q.res_z     <= lane_res[2];
      out_q.saturated <= |lane_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.cmd == avt_pkg::CMD_LOAD |=> !valid_a_q)
    else $error("load word entered the vector pipeline");

  a_vec_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_vec |=> valid_a_q)
    else $error("vector word not captured");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({valid_a_q, valid_b_q, valid_c_q, valid_d_q, valid_e_q}))
    else $error("pipeline moved while stalled");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_e_q && en |=> out_valid_q)
    else $error("result lost at merge stage");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the affine vector transform: directed table, then random words.
`timescale 1ns / 1ps

module tb;

  localparam int W           = avt_pkg::WORD_W;
  localparam int FRAC        = avt_pkg::FRAC_BITS_DEF;
  localparam int ITEMS       = 1500;
  localparam int DRAIN       = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_GAP     = 17;
  localparam int CMD_TOP     = 7;
  localparam int IDX_TOP     = 15;
  localparam int MTX_SPAN    = 18;
  localparam int VEC_SPAN    = 26;
  localparam logic signed [W-1:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [W-1:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [W-1:0] ONE   = 1 << FRAC;
  localparam avt_pkg::out_word_t NO_WANT = '0;

  typedef struct {
    avt_pkg::in_word_t  w;
    bit                 typed;
    avt_pkg::out_word_t want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  avt_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  avt_pkg::out_word_t out_word;

  avt_pkg::out_word_t  result_q [$];
  logic signed [W-1:0] mtx_model [avt_pkg::NUM_WORDS];
  bit                  clip_hit;
  bit                  calm = 1'b0;
  bit                  hold_long = 1'b0;
  int                  errors = 0;

  affine_vector_transform_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #4 clk = ~clk;

  function automatic logic signed [W-1:0] clamp(input longint v);
    if (v > longint'(W_MAX)) begin
      clip_hit = 1'b1;
      return W_MAX;
    end
    if (v < longint'(W_MIN)) begin
      clip_hit = 1'b1;
      return W_MIN;
    end
    return v[W-1:0];
  endfunction

  // full product, arithmetic shift rounds toward minus infinity
  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp(p >>> FRAC);
  endfunction

  function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return clamp(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return clamp(longint'(a) - longint'(b));
  endfunction

  task automatic xform_predict(input avt_pkg::in_word_t w, output bit has,
                               output avt_pkg::out_word_t r);
    logic signed [W-1:0] v [avt_pkg::NUM_LANES];
    logic signed [W-1:0] acc [avt_pkg::NUM_LANES];
    int k;
    has = 1'b0;
    r = '0;
    v[0] = w.vec_x;
    v[1] = w.vec_y;
    v[2] = w.vec_z;
    clip_hit = 1'b0;
    case (w.cmd)
      avt_pkg::CMD_LOAD: begin
        if (w.elem_index < avt_pkg::NUM_WORDS) mtx_model[w.elem_index] = w.elem_value;
      end
      avt_pkg::CMD_XFORM, avt_pkg::CMD_ROT: begin
        for (k = 0; k < avt_pkg::NUM_LANES; k++) begin
          acc[k] = qmul(v[0], mtx_model[k]);
          acc[k] = qadd(acc[k], qmul(v[1], mtx_model[avt_pkg::NUM_LANES + k]));
          acc[k] = qadd(acc[k], qmul(v[2], mtx_model[2 * avt_pkg::NUM_LANES + k]));
          if (w.cmd == avt_pkg::CMD_XFORM)
            acc[k] = qadd(acc[k], mtx_model[avt_pkg::TRANS_BASE + k]);
        end
        has = 1'b1;
      end
      avt_pkg::CMD_INV_XFORM, avt_pkg::CMD_INV_ROT: begin
        if (w.cmd == avt_pkg::CMD_INV_XFORM) begin
          for (k = 0; k < avt_pkg::NUM_LANES; k++)
            v[k] = qsub(v[k], mtx_model[avt_pkg::TRANS_BASE + k]);
        end
        for (k = 0; k < avt_pkg::NUM_LANES; k++) begin
          acc[k] = qmul(v[0], mtx_model[avt_pkg::NUM_LANES * k]);
          acc[k] = qadd(acc[k], qmul(v[1], mtx_model[avt_pkg::NUM_LANES * k + 1]));
          acc[k] = qadd(acc[k], qmul(v[2], mtx_model[avt_pkg::NUM_LANES * k + 2]));
        end
        has = 1'b1;
      end
      default: ;
    endcase
    if (has) r = '{acc[0], acc[1], acc[2], clip_hit};
  endtask

  function automatic avt_pkg::in_word_t mk(input int cmd, input int idx,
                                           input logic [W-1:0] val,
                                           input logic [W-1:0] x, y, z);
    avt_pkg::in_word_t w;
    w.cmd        = 3'(cmd);
    w.elem_index = 4'(idx);
    w.elem_value = val;
    w.vec_x      = x;
    w.vec_y      = y;
    w.vec_z      = z;
    return w;
  endfunction

  function automatic avt_pkg::out_word_t ow(input logic [W-1:0] x, y, z, input logic sat);
    return '{x, y, z, sat};
  endfunction

  // within +/- 2^(span_bits-1) LSBs with chance odds/(odds+1), else extremes or full range
  function automatic logic [W-1:0] rnd_word(input int span_bits, input int odds);
    if ($urandom_range(0, odds) != 0)
      return $urandom_range(0, (1 << span_bits) - 1) - (1 << (span_bits - 1));
    case ($urandom_range(0, 3))
      0: return W_MAX;
      1: return W_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic report(input string what, input logic [W-1:0] got,
                        input logic [W-1:0] want);
    errors++;
    if (errors <= 100) $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  task automatic send(input avt_pkg::in_word_t w, input bit typed,
                      input avt_pkg::out_word_t want);
    int gap;
    bit has;
    avt_pkg::out_word_t pred;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    xform_predict(w, has, pred);
    if (has) result_q.push_back(typed ? want : pred);
  endtask

  always @(posedge clk) begin : chk
    avt_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report("word with none pending", out_word.res_x, '0);
      end else begin
        want = result_q.pop_front();
        if (out_word.res_x !== want.res_x) report("res_x", out_word.res_x, want.res_x);
        if (out_word.res_y !== want.res_y) report("res_y", out_word.res_y, want.res_y);
        if (out_word.res_z !== want.res_z) report("res_z", out_word.res_z, want.res_z);
        if (out_word.saturated !== want.saturated)
          report("saturated", out_word.saturated, want.saturated);
      end
    end
  end

  initial begin : rx
    int n;
    wait (rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_long) begin
        n = HOLD_CYCLES;
        hold_long = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stim
    row_t plan [$];
    int work, k, idx, pick;
    bit held, drained;
    for (k = 0; k < avt_pkg::NUM_WORDS; k++) mtx_model[k] = '0;
    for (k = 0; k < avt_pkg::NUM_LANES; k++) mtx_model[k * (avt_pkg::NUM_LANES + 1)] = ONE;
    held = 1'b0;
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back('{mk(avt_pkg::CMD_XFORM, $urandom, $urandom, ONE, 2 * ONE, 3 * ONE),
                     1'b1, ow(ONE, 2 * ONE, 3 * ONE, 1'b0)});
    plan.push_back('{mk(avt_pkg::CMD_ROT, $urandom, $urandom, W_MAX, W_MIN, '0), 1'b1,
                     ow(W_MAX, W_MIN, '0, 1'b0)});
    plan.push_back('{mk(avt_pkg::CMD_INV_ROT, $urandom, $urandom, W_MAX, W_MIN, '0), 1'b1,
                     ow(W_MAX, W_MIN, '0, 1'b0)});
    plan.push_back('{mk(avt_pkg::CMD_INV_XFORM, $urandom, $urandom, '1, '1, '1), 1'b1,
                     ow('1, '1, '1, 1'b0)});
    plan.push_back('{mk(avt_pkg::CMD_LOAD, avt_pkg::TRANS_BASE, W_MAX, $urandom, $urandom,
                        $urandom), 1'b0, NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_XFORM, $urandom, $urandom, ONE, '0, '0), 1'b1,
                     ow(W_MAX, '0, '0, 1'b1)});
    plan.push_back('{mk(avt_pkg::CMD_INV_XFORM, $urandom, $urandom, W_MIN, '0, '0), 1'b1,
                     ow(W_MIN, '0, '0, 1'b1)});
    plan.push_back('{mk(avt_pkg::CMD_LOAD, avt_pkg::NUM_WORDS, $urandom, $urandom, $urandom,
                        $urandom), 1'b0, NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_LOAD, IDX_TOP, $urandom, $urandom, $urandom, $urandom),
                     1'b0, NO_WANT});
    for (k = avt_pkg::CMD_INV_ROT + 1; k <= CMD_TOP; k++)
      plan.push_back('{mk(k, $urandom, $urandom, $urandom, $urandom, $urandom), 1'b0,
                       NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_XFORM, $urandom, $urandom, rnd_word(VEC_SPAN, 0),
                        rnd_word(VEC_SPAN, 0), rnd_word(VEC_SPAN, 0)), 1'b0, NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_LOAD, 0, W_MIN, $urandom, $urandom, $urandom), 1'b0,
                     NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_ROT, $urandom, $urandom, W_MIN, '0, '0), 1'b1,
                     ow(W_MAX, '0, '0, 1'b1)});
    plan.push_back('{mk(avt_pkg::CMD_LOAD, 0, '1, $urandom, $urandom, $urandom), 1'b0,
                     NO_WANT});
    // negative product must round down, not toward zero
    plan.push_back('{mk(avt_pkg::CMD_ROT, $urandom, $urandom, 1, '0, '0), 1'b1,
                     ow('1, '0, '0, 1'b0)});
    plan.push_back('{mk(avt_pkg::CMD_INV_ROT, $urandom, $urandom, rnd_word(VEC_SPAN, 0),
                        rnd_word(VEC_SPAN, 0), rnd_word(VEC_SPAN, 0)), 1'b0, NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_INV_XFORM, $urandom, $urandom, rnd_word(VEC_SPAN, 0),
                        rnd_word(VEC_SPAN, 0), rnd_word(VEC_SPAN, 0)), 1'b0, NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_ROT, IDX_TOP, W_MAX, W_MAX, W_MAX, W_MAX), 1'b0,
                     NO_WANT});
    plan.push_back('{mk(avt_pkg::CMD_INV_XFORM, $urandom, $urandom, W_MIN, W_MIN, W_MIN),
                     1'b0, NO_WANT});

    foreach (plan[i]) send(plan[i].w, plan[i].typed, plan[i].want);

    work = 0;
    while (work < ITEMS) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 63) == 0) calm = ($urandom_range(0, 2) == 0);
      if (!held && work >= ITEMS / 4) begin
        held = 1'b1;
        hold_long = 1'b1;
      end
      if (!drained && work >= ITEMS / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (result_q.size() != 0);
      end
      if (pick < 3) begin
        for (k = 0; k < avt_pkg::NUM_WORDS; k++)
          send(mk(avt_pkg::CMD_LOAD, k, rnd_word(MTX_SPAN, 7), $urandom, $urandom,
                  $urandom), 1'b0, NO_WANT);
        work += avt_pkg::NUM_WORDS;
      end else if (pick < 10) begin
        idx = ($urandom_range(0, 7) == 0) ? $urandom_range(avt_pkg::NUM_WORDS, IDX_TOP)
                                          : $urandom_range(0, avt_pkg::NUM_WORDS - 1);
        send(mk(avt_pkg::CMD_LOAD, idx, rnd_word(MTX_SPAN, 7), $urandom, $urandom,
                $urandom), 1'b0, NO_WANT);
        if (idx < avt_pkg::NUM_WORDS) work++;
      end else if (pick < 14) begin
        send(mk($urandom_range(avt_pkg::CMD_INV_ROT + 1, CMD_TOP), $urandom, $urandom,
                $urandom, $urandom, $urandom), 1'b0, NO_WANT);
      end else begin
        send(mk($urandom_range(avt_pkg::CMD_XFORM, avt_pkg::CMD_INV_ROT), $urandom,
                $urandom, rnd_word(VEC_SPAN, 3), rnd_word(VEC_SPAN, 3),
                rnd_word(VEC_SPAN, 3)), 1'b0, NO_WANT);
        work++;
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
